// ===== src/mpenc_pkg.sv =====
package mpenc_pkg;

    localparam int ValueWidth = 64;
    localparam int ByteWidth  = 8;
    localparam int CountWidth = 4;

    // token kinds
    localparam logic [3:0] MODE_NIL   = 4'd0;
    localparam logic [3:0] MODE_BOOL  = 4'd1;
    localparam logic [3:0] MODE_SINT  = 4'd2;
    localparam logic [3:0] MODE_UINT  = 4'd3;
    localparam logic [3:0] MODE_FLOAT = 4'd4;
    localparam logic [3:0] MODE_STR   = 4'd5;
    localparam logic [3:0] MODE_BIN   = 4'd6;
    localparam logic [3:0] MODE_ARRAY = 4'd7;
    localparam logic [3:0] MODE_MAP   = 4'd8;
    localparam logic [3:0] MODE_RAW   = 4'd9;

    // header codes
    localparam logic [7:0] HDR_FIXMAP  = 8'h80;
    localparam logic [7:0] HDR_FIXARR  = 8'h90;
    localparam logic [7:0] HDR_FIXSTR  = 8'hA0;
    localparam logic [7:0] HDR_NIL     = 8'hC0;
    localparam logic [7:0] HDR_FALSE   = 8'hC2;
    localparam logic [7:0] HDR_BIN8    = 8'hC4;
    localparam logic [7:0] HDR_BIN16   = 8'hC5;
    localparam logic [7:0] HDR_BIN32   = 8'hC6;
    localparam logic [7:0] HDR_FLOAT64 = 8'hCB;
    localparam logic [7:0] HDR_UINT8   = 8'hCC;
    localparam logic [7:0] HDR_UINT16  = 8'hCD;
    localparam logic [7:0] HDR_UINT32  = 8'hCE;
    localparam logic [7:0] HDR_UINT64  = 8'hCF;
    localparam logic [7:0] HDR_INT8    = 8'hD0;
    localparam logic [7:0] HDR_INT16   = 8'hD1;
    localparam logic [7:0] HDR_INT32   = 8'hD2;
    localparam logic [7:0] HDR_INT64   = 8'hD3;
    localparam logic [7:0] HDR_STR8    = 8'hD9;
    localparam logic [7:0] HDR_STR16   = 8'hDA;
    localparam logic [7:0] HDR_STR32   = 8'hDB;
    localparam logic [7:0] HDR_ARR16   = 8'hDC;
    localparam logic [7:0] HDR_ARR32   = 8'hDD;
    localparam logic [7:0] HDR_MAP16   = 8'hDE;
    localparam logic [7:0] HDR_MAP32   = 8'hDF;
    localparam logic [7:0] HDR_ERROR   = 8'h00;

    localparam logic [CountWidth-1:0] N0 = 4'd0;
    localparam logic [CountWidth-1:0] N1 = 4'd1;
    localparam logic [CountWidth-1:0] N2 = 4'd2;
    localparam logic [CountWidth-1:0] N4 = 4'd4;
    localparam logic [CountWidth-1:0] N8 = 4'd8;

    typedef struct packed {
        logic [ByteWidth-1:0]  hdr;
        logic [CountWidth-1:0] nbytes;
        logic                  err;
    } enc_t;

endpackage

// ===== src/mpenc_classify.sv =====
module mpenc_classify
    import mpenc_pkg::*;
(
    input  logic [3:0]            mode,
    input  logic [ValueWidth-1:0] value,
    output enc_t                  enc
);

    logic len_wide;
    logic hi_zero7, hi_zero8, hi_zero16, hi_zero32;
    logic hi_ones5, hi_ones7, hi_ones15, hi_ones31;
    logic [ByteWidth-1:0]  uhdr;
    logic [CountWidth-1:0] un;

    assign hi_zero7  = (value[63:7] == '0);
    assign hi_zero8  = (value[63:8] == '0);
    assign hi_zero16 = (value[63:16] == '0);
    assign hi_zero32 = (value[63:32] == '0);
    assign hi_ones5  = &value[63:5];
    assign hi_ones7  = &value[63:7];
    assign hi_ones15 = &value[63:15];
    assign hi_ones31 = &value[63:31];
    assign len_wide  = !hi_zero32;

    // smallest unsigned form
    always_comb
    begin
        if (hi_zero7)
        begin
            uhdr = value[7:0];
            un   = N0;
        end
        else if (hi_zero8)
        begin
            uhdr = HDR_UINT8;
            un   = N1;
        end
        else if (hi_zero16)
        begin
            uhdr = HDR_UINT16;
            un   = N2;
        end
        else if (hi_zero32)
        begin
            uhdr = HDR_UINT32;
            un   = N4;
        end
        else
        begin
            uhdr = HDR_UINT64;
            un   = N8;
        end
    end

    always_comb
    begin
        enc.hdr    = HDR_ERROR;
        enc.nbytes = N0;
        enc.err    = 1'b0;
        case (mode)
            MODE_NIL:   enc.hdr = HDR_NIL;
            MODE_BOOL:  enc.hdr = {HDR_FALSE[7:1], value[0]};
            MODE_SINT:
            begin
                if (!value[63])
                begin
                    enc.hdr    = uhdr;
                    enc.nbytes = un;
                end
                else if (hi_ones5)
                    enc.hdr = value[7:0];
                else if (hi_ones7)
                begin
                    enc.hdr    = HDR_INT8;
                    enc.nbytes = N1;
                end
                else if (hi_ones15)
                begin
                    enc.hdr    = HDR_INT16;
                    enc.nbytes = N2;
                end
                else if (hi_ones31)
                begin
                    enc.hdr    = HDR_INT32;
                    enc.nbytes = N4;
                end
                else
                begin
                    enc.hdr    = HDR_INT64;
                    enc.nbytes = N8;
                end
            end
            MODE_UINT:
            begin
                enc.hdr    = uhdr;
                enc.nbytes = un;
            end
            MODE_FLOAT:
            begin
                enc.hdr    = HDR_FLOAT64;
                enc.nbytes = N8;
            end
            MODE_STR:
            begin
                if (len_wide)
                    enc.err = 1'b1;
                else if (value[31:5] == '0)
                    enc.hdr = HDR_FIXSTR | value[7:0];
                else if (hi_zero8)
                begin
                    enc.hdr    = HDR_STR8;
                    enc.nbytes = N1;
                end
                else if (hi_zero16)
                begin
                    enc.hdr    = HDR_STR16;
                    enc.nbytes = N2;
                end
                else
                begin
                    enc.hdr    = HDR_STR32;
                    enc.nbytes = N4;
                end
            end
            MODE_BIN:
            begin
                if (len_wide)
                    enc.err = 1'b1;
                else if (hi_zero8)
                begin
                    enc.hdr    = HDR_BIN8;
                    enc.nbytes = N1;
                end
                else if (hi_zero16)
                begin
                    enc.hdr    = HDR_BIN16;
                    enc.nbytes = N2;
                end
                else
                begin
                    enc.hdr    = HDR_BIN32;
                    enc.nbytes = N4;
                end
            end
            MODE_ARRAY, MODE_MAP:
            begin
                if (len_wide)
                    enc.err = 1'b1;
                else if (value[31:4] == '0)
                    enc.hdr = ((mode == MODE_MAP) ? HDR_FIXMAP : HDR_FIXARR) | value[7:0];
                else if (hi_zero16)
                begin
                    enc.hdr    = (mode == MODE_MAP) ? HDR_MAP16 : HDR_ARR16;
                    enc.nbytes = N2;
                end
                else
                begin
                    enc.hdr    = (mode == MODE_MAP) ? HDR_MAP32 : HDR_ARR32;
                    enc.nbytes = N4;
                end
            end
            MODE_RAW:   enc.hdr = value[7:0];
            default:    enc.err = 1'b1;
        endcase
    end

endmodule

// ===== src/mpenc_serializer.sv =====
module mpenc_serializer
    import mpenc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  tok_valid,
    input  enc_t                  enc,
    input  logic [ValueWidth-1:0] value,
    output logic                  load,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [ByteWidth-1:0]  out_byte,
    output logic                  last,
    output logic                  error
);

    logic                  valid_reg, valid_next;
    logic [ByteWidth-1:0]  byte_reg, byte_next;
    logic                  last_reg, last_next;
    logic                  err_reg, err_next;
    logic [ValueWidth-1:0] pend_reg, pend_next;
    logic [CountWidth-1:0] left_reg, left_next;
    logic [ValueWidth-1:0] aligned;
    logic                  adv;

    // operand bytes moved to the top so they leave msb first
    always_comb
    begin
        case (enc.nbytes)
            N1:      aligned = {value[7:0], {(ValueWidth-8){1'b0}}};
            N2:      aligned = {value[15:0], {(ValueWidth-16){1'b0}}};
            N4:      aligned = {value[31:0], {(ValueWidth-32){1'b0}}};
            default: aligned = value;
        endcase
    end

    assign adv  = !valid_reg || out_ready;
    assign load = adv && (left_reg == N0) && tok_valid;

    always_comb
    begin
        valid_next = valid_reg;
        byte_next  = byte_reg;
        last_next  = last_reg;
        err_next   = err_reg;
        pend_next  = pend_reg;
        left_next  = left_reg;
        if (adv)
        begin
            if (left_reg != N0)
            begin
                valid_next = 1'b1;
                byte_next  = pend_reg[ValueWidth-1 -: ByteWidth];
                last_next  = (left_reg == N1);
                err_next   = 1'b0;
                pend_next  = {pend_reg[ValueWidth-ByteWidth-1:0], {ByteWidth{1'b0}}};
                left_next  = left_reg - N1;
            end
            else if (tok_valid)
            begin
                valid_next = 1'b1;
                byte_next  = enc.hdr;
                last_next  = (enc.nbytes == N0);
                err_next   = enc.err;
                pend_next  = aligned;
                left_next  = enc.nbytes;
            end
            else
                valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            left_reg  <= N0;
        end
        else
        begin
            valid_reg <= valid_next;
            left_reg  <= left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        last_reg <= last_next;
        err_reg  <= err_next;
        pend_reg <= pend_next;
    end

    assign out_valid = valid_reg;
    assign out_byte  = byte_reg;
    assign last      = last_reg;
    assign error     = err_reg;

endmodule

// ===== src/messagepack_value_encoder.sv =====
// MessagePack value encoder.
// Input channel (in_valid/in_ready, mode, value) takes one value token per
// request; output channel (out_valid/out_ready, out_byte, last, error) gives
// its encoding one byte per request, most significant first, last on the
// final byte. Strings, binary, arrays and maps give their header only; send
// payload bytes as raw-byte tokens. Unknown kinds and lengths wider than
// 32 bits give a single byte 0x00 with last and error set.
// The token is taken into the input register, classified combinationally
// out of it and loaded into the output register as its header byte.
// A token gives 1 + n bytes on the output, n = 0, 1, 2, 4 or 8 operand bytes,
// so 1 to 9 bytes; the output register is the shared unit and gives one byte
// per cycle while out_ready is high, with no gap between tokens if one waits.
// The next token is held in the input register while the current one
// drains, so one token can be waiting.
// Reset clears both valid flags and the byte count; nothing is in flight.
// When the receiver stalls, the output byte holds and in_ready drops once
// the input register is full.
module messagepack_value_encoder
    import mpenc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [3:0]            mode,
    input  logic [ValueWidth-1:0] value,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [ByteWidth-1:0]  out_byte,
    output logic                  last,
    output logic                  error
);

    logic                  tok_valid_reg;
    logic [3:0]            mode_reg;
    logic [ValueWidth-1:0] value_reg;
    logic                  load;
    enc_t                  enc;

    assign in_ready = !tok_valid_reg || load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tok_valid_reg <= 1'b0;
        else if (in_ready)
            tok_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            mode_reg  <= mode;
            value_reg <= value;
        end
    end

    mpenc_classify u_classify (
        .mode  (mode_reg),
        .value (value_reg),
        .enc   (enc)
    );

    mpenc_serializer u_serializer (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok_valid (tok_valid_reg),
        .enc       (enc),
        .value     (value_reg),
        .load      (load),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .last      (last),
        .error     (error)
    );

endmodule

// ===== src/mpenc_checker.sv =====
module mpenc_checker
    import mpenc_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_ready,
    input logic [3:0]            mode,
    input logic [ValueWidth-1:0] value,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic [ByteWidth-1:0]  out_byte,
    input logic                  last,
    input logic                  error
);

    // stalled output request holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte)
            && $stable(last) && $stable(error))
        else $error("output changed while stalled");

    // error result is a single zero byte
    a_err_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error |-> last && out_byte == HDR_ERROR)
        else $error("malformed error result");

    // a token's bytes come back to back
    a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last |=> out_valid)
        else $error("gap inside a token");

    // input only backs up behind a busy output
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with output idle");

endmodule

bind messagepack_value_encoder mpenc_checker u_checker (.*);
